### rtl/spatial_hash_range_query_defines.svh
// Assertion macros for the spatial hash range query block.
// No dependencies; included by the top level.
`ifndef SPATIAL_HASH_RANGE_QUERY_DEFINES_SVH
`define SPATIAL_HASH_RANGE_QUERY_DEFINES_SVH

// a holds at this edge, so c holds at the same edge
`define SHRQ_ASSERT_NOW(lbl, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// a holds at this edge, so c holds at the next edge
`define SHRQ_ASSERT_NEXT(lbl, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

### rtl/shrq_pkg.sv
// Shared types, codes and widths of the spatial hash range query block.
// No dependencies.
package shrq_pkg;

    localparam int MAX_OBJECTS_DEF = 64;
    localparam int COORD_BITS_DEF  = 10;

    localparam int KIND_W   = 2;
    localparam int ID_W     = 6;
    localparam int POS_W    = 10;
    localparam int STATUS_W = 3;
    localparam int DIST_W   = 21;
    localparam int RANGE_W  = 10;
    localparam int GRID_W   = 11;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 11;

    localparam logic [KIND_W-1:0] KIND_UPSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_BOUND = 2'd1;
    localparam logic [1:0] MODE_AREA  = 2'd2;

    localparam logic [CFG_AW-1:0] CFG_MODE  = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_RANGE = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_CELL  = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_GW    = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_GH    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_NEW      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MOVED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_HIT      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOHIT    = 3'd5;
    localparam logic [STATUS_W-1:0] ST_MISCONF  = 3'd6;

    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] dsq;
        logic [ID_W-1:0]   id;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
    } sort_ent_t;

endpackage

### rtl/shrq_if.sv
// Channel interfaces of the spatial hash range query block.
// Depends on shrq_pkg.
interface shrq_req_if;
    logic                          valid;
    logic                          ready;
    logic [shrq_pkg::KIND_W-1:0]   kind;
    logic [shrq_pkg::ID_W-1:0]     object_id;
    logic [shrq_pkg::POS_W-1:0]    pos_x;
    logic [shrq_pkg::POS_W-1:0]    pos_y;
    modport source (output valid, kind, object_id, pos_x, pos_y, input ready);
    modport sink (input valid, kind, object_id, pos_x, pos_y, output ready);
endinterface

interface shrq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [shrq_pkg::STATUS_W-1:0] status;
    logic [shrq_pkg::ID_W-1:0]     hit_id;
    logic [shrq_pkg::POS_W-1:0]    hit_x;
    logic [shrq_pkg::POS_W-1:0]    hit_y;
    logic [shrq_pkg::DIST_W-1:0]   distance_sq;
    logic                          last;
    modport source (output valid, status, hit_id, hit_x, hit_y, distance_sq, last,
                    input ready);
    modport sink (input valid, status, hit_id, hit_x, hit_y, distance_sq, last,
                  output ready);
endinterface

interface shrq_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [shrq_pkg::CFG_AW-1:0]   addr;
    logic [shrq_pkg::CFG_DW-1:0]   data;
    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface

### rtl/shrq_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on shrq_pkg.
module shrq_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [shrq_pkg::GRID_W-1:0] num,
    input  logic [shrq_pkg::GRID_W-1:0] den,
    output logic                        done,
    output logic [shrq_pkg::GRID_W-1:0] quot
);

    localparam int NW = shrq_pkg::GRID_W;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] rem_reg, num_reg, den_reg, quot_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [NW:0]   rem_sh;
    logic          ge;

    assign rem_sh = {rem_reg, num_reg[NW-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            num_reg  <= num;
            den_reg  <= den;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? NW'(rem_sh - {1'b0, den_reg}) : rem_sh[NW-1:0];
            num_reg  <= {num_reg[NW-2:0], 1'b0};
            quot_reg <= {quot_reg[NW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

### rtl/shrq_sort_cell.sv
// One cell of the sorted hit chain: insert by (distance, arrival), shift out to cell 0.
// Depends on shrq_pkg.
module shrq_sort_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clear,
    input  logic                ins,
    input  logic                pop,
    input  shrq_pkg::sort_ent_t new_ent,
    input  shrq_pkg::sort_ent_t prev_ent,
    input  logic                prev_lt,
    input  shrq_pkg::sort_ent_t next_ent,
    output shrq_pkg::sort_ent_t ent,
    output logic                lt
);

    shrq_pkg::sort_ent_t ent_reg;

    // empty cells count as infinitely far; equal distance stays ahead
    assign lt = !ent_reg.valid || (new_ent.dsq < ent_reg.dsq);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ent_reg <= '0;
        else if (clear)
            ent_reg.valid <= 1'b0;
        else if (pop)
            ent_reg <= next_ent;
        else if (ins && lt)
            ent_reg <= prev_lt ? prev_ent : new_ent;
    end

    assign ent = ent_reg;

endmodule

### rtl/spatial_hash_range_query.sv
// Spatial hash range query, top level: slot table, scan pipeline, hit chain.
// Depends on shrq_pkg, shrq_if, shrq_div, shrq_sort_cell, the defines header.
//
//  channel | dir | beat
//  req     | in  | kind, object_id, pos_x, pos_y
//  rsp     | out | status, hit_id, hit_x, hit_y, distance_sq, last
//  cfg     | in  | addr, data (register write)
//
// One item at a time. Each divide runs bit-serially from start to done.
// Upsert: two divides, then the beat.
// Search: four divides, then the slot scan, then one beat per hit (one no-hit beat if
// none). Remove and misconfigured search answer in the cycle after the req beat.
// The divider and the one-slot-per-cycle table read set how long an item takes.
// rsp stalls hold the chain; req is not taken until the last beat leaves.
`include "spatial_hash_range_query_defines.svh"

module spatial_hash_range_query
#(
    parameter int MAX_OBJECTS = shrq_pkg::MAX_OBJECTS_DEF,
    parameter int COORD_BITS  = shrq_pkg::COORD_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    shrq_req_if.sink      req,
    shrq_rsp_if.source    rsp,
    shrq_cfg_if.sink      cfg
);

    localparam int CW  = (COORD_BITS < shrq_pkg::POS_W) ? COORD_BITS : shrq_pkg::POS_W;
    localparam int IW  = $clog2(MAX_OBJECTS);
    localparam int NW  = shrq_pkg::GRID_W;
    localparam int SCW = $clog2(MAX_OBJECTS + 5);
    localparam int MW  = 4 * CW;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_EMIT = 3'd3;
    localparam logic [2:0] S_RESP = 3'd4;

    logic [2:0]                      state_reg, state_next;
    logic [1:0]                      mode_reg;
    logic [shrq_pkg::RANGE_W-1:0]    range_reg;
    logic [NW-1:0]                   csize_reg, gw_reg, gh_reg;

    logic [shrq_pkg::KIND_W-1:0]     kind_reg;
    logic [IW-1:0]                   id_reg;
    logic [CW-1:0]                   px_reg, py_reg;
    logic [NW-1:0]                   win_reg [4];
    logic [NW-1:0]                   q_reg [4];
    logic [1:0]                      sel_reg, nsel_reg;
    logic                            div_go_reg;
    logic [shrq_pkg::STATUS_W-1:0]   rstat_reg;
    logic [SCW-1:0]                  sc_reg;
    logic [MAX_OBJECTS-1:0]          slot_valid_reg;

    logic [MW-1:0]                   mem [MAX_OBJECTS];
    logic [MW-1:0]                   rd_reg;

    logic                            p1_v_reg, p1_sv_reg;
    logic [IW-1:0]                   p1_id_reg;
    logic                            p2_v_reg, p3_v_reg, p4_v_reg;
    logic [IW-1:0]                   p2_id_reg, p3_id_reg, p4_id_reg;
    logic [CW-1:0]                   p2_x_reg, p2_y_reg, p3_x_reg, p3_y_reg;
    logic [CW-1:0]                   p4_x_reg, p4_y_reg;
    logic [CW-1:0]                   p2_dx_reg, p2_dy_reg;
    logic [2*CW-1:0]                 p3_dxx_reg, p3_dyy_reg;
    logic [shrq_pkg::DIST_W-1:0]     p4_d_reg;

    logic                            req_acc, rsp_acc, id_ok;
    logic [CW-1:0]                   in_px, in_py;
    logic [NW:0]                     xr, yr;
    logic [NW-1:0]                   w_left, w_right, w_bottom, w_top, den;
    logic                            div_done;
    logic [NW-1:0]                   div_quot;
    logic                            last_div, mem_we, issue, chain_clear, pop;
    logic [CW-1:0]                   s_x, s_y, s_cx, s_cy, dx, dy;
    logic [shrq_pkg::RANGE_W-1:0]    dxe, dye;
    logic                            incell, hit;
    shrq_pkg::sort_ent_t             new_ent;
    shrq_pkg::sort_ent_t             cent [MAX_OBJECTS];
    shrq_pkg::sort_ent_t             pent [MAX_OBJECTS];
    shrq_pkg::sort_ent_t             nent [MAX_OBJECTS];
    logic                            clt [MAX_OBJECTS];
    logic                            plt [MAX_OBJECTS];
    logic                            emit_last;

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == S_IDLE);
    assign req_acc   = req.valid && req.ready;
    assign rsp_acc   = rsp.valid && rsp.ready;
    assign id_ok     = int'(req.object_id) < MAX_OBJECTS;
    assign in_px     = req.pos_x[CW-1:0];
    assign in_py     = req.pos_y[CW-1:0];

    // search window clipped to the grid
    assign xr       = (NW+1)'(in_px) + (NW+1)'(range_reg);
    assign yr       = (NW+1)'(in_py) + (NW+1)'(range_reg);
    assign w_right  = (xr > (NW+1)'(gw_reg)) ? gw_reg : xr[NW-1:0];
    assign w_top    = (yr > (NW+1)'(gh_reg)) ? gh_reg : yr[NW-1:0];
    assign w_left   = (NW'(in_px) >= NW'(range_reg)) ? NW'(in_px) - NW'(range_reg) : '0;
    assign w_bottom = (NW'(in_py) >= NW'(range_reg)) ? NW'(in_py) - NW'(range_reg) : '0;
    assign den      = (csize_reg == '0) ? NW'(1) : csize_reg;

    assign last_div    = div_done && (sel_reg == nsel_reg);
    assign mem_we      = (state_reg == S_DIV) && last_div && (kind_reg == shrq_pkg::KIND_UPSERT);
    assign issue       = (state_reg == S_SCAN) && (sc_reg < SCW'(MAX_OBJECTS));
    assign chain_clear = req_acc && (req.kind == shrq_pkg::KIND_SEARCH);
    assign pop         = (state_reg == S_EMIT) && rsp_acc;

    shrq_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_go_reg),
        .num   (win_reg[sel_reg]),
        .den   (den),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= shrq_pkg::MODE_NONE;
            range_reg <= shrq_pkg::RANGE_W'(1);
            csize_reg <= NW'(8);
            gw_reg    <= NW'(1024);
            gh_reg    <= NW'(1024);
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.addr)
                shrq_pkg::CFG_MODE:  mode_reg  <= cfg.data[1:0];
                shrq_pkg::CFG_RANGE: range_reg <= cfg.data[shrq_pkg::RANGE_W-1:0];
                shrq_pkg::CFG_CELL:  csize_reg <= cfg.data[NW-1:0];
                shrq_pkg::CFG_GW:    gw_reg    <= cfg.data[NW-1:0];
                shrq_pkg::CFG_GH:    gh_reg    <= cfg.data[NW-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    case (req.kind)
                        shrq_pkg::KIND_UPSERT: state_next = id_ok ? S_DIV : S_RESP;
                        shrq_pkg::KIND_REMOVE: state_next = S_RESP;
                        shrq_pkg::KIND_SEARCH:
                            state_next = (mode_reg == shrq_pkg::MODE_BOUND ||
                                          mode_reg == shrq_pkg::MODE_AREA) ? S_DIV : S_RESP;
                        default:               state_next = S_IDLE;
                    endcase
                end
            end
            S_DIV:
            begin
                if (last_div)
                    state_next = (kind_reg == shrq_pkg::KIND_UPSERT) ? S_RESP : S_SCAN;
            end
            S_SCAN:
            begin
                if (sc_reg == SCW'(MAX_OBJECTS + 4))
                    state_next = cent[0].valid ? S_EMIT : S_RESP;
            end
            S_EMIT:
            begin
                if (rsp_acc && emit_last)
                    state_next = S_IDLE;
            end
            S_RESP:
            begin
                if (rsp_acc)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            div_go_reg     <= 1'b0;
            sel_reg        <= 2'd0;
            sc_reg         <= '0;
            slot_valid_reg <= '0;
            p1_v_reg       <= 1'b0;
            p2_v_reg       <= 1'b0;
            p3_v_reg       <= 1'b0;
            p4_v_reg       <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            div_go_reg <= 1'b0;
            p1_v_reg   <= issue;
            p2_v_reg   <= p1_v_reg && p1_sv_reg && incell && hit;
            p3_v_reg   <= p2_v_reg;
            p4_v_reg   <= p3_v_reg;
            if (req_acc)
            begin
                sel_reg    <= 2'd0;
                div_go_reg <= (state_next == S_DIV);
                if (req.kind == shrq_pkg::KIND_REMOVE && id_ok)
                    slot_valid_reg[req.object_id[IW-1:0]] <= 1'b0;
            end
            if (state_reg == S_DIV && div_done && !last_div)
            begin
                sel_reg    <= sel_reg + 2'd1;
                div_go_reg <= 1'b1;
            end
            if (mem_we)
                slot_valid_reg[id_reg] <= 1'b1;
            if (state_reg == S_SCAN)
                sc_reg <= sc_reg + 1'b1;
            else
                sc_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            kind_reg <= req.kind;
            id_reg   <= req.object_id[IW-1:0];
            px_reg   <= in_px;
            py_reg   <= in_py;
            if (req.kind == shrq_pkg::KIND_UPSERT)
            begin
                win_reg[0] <= NW'(in_px);
                win_reg[1] <= NW'(in_py);
                win_reg[2] <= '0;
                win_reg[3] <= '0;
                nsel_reg   <= 2'd1;
                rstat_reg  <= shrq_pkg::ST_NOTFOUND;
            end
            else
            begin
                win_reg[0] <= w_left;
                win_reg[1] <= w_right;
                win_reg[2] <= w_bottom;
                win_reg[3] <= w_top;
                nsel_reg   <= 2'd3;
                if (req.kind == shrq_pkg::KIND_REMOVE)
                    rstat_reg <= (id_ok && slot_valid_reg[req.object_id[IW-1:0]]) ?
                                 shrq_pkg::ST_REMOVED : shrq_pkg::ST_NOTFOUND;
                else
                    rstat_reg <= shrq_pkg::ST_MISCONF;
            end
        end
        if (state_reg == S_DIV && div_done)
            q_reg[sel_reg] <= div_quot;
        if (mem_we)
            rstat_reg <= slot_valid_reg[id_reg] ? shrq_pkg::ST_MOVED : shrq_pkg::ST_NEW;
        if (state_reg == S_SCAN && state_next == S_RESP)
            rstat_reg <= shrq_pkg::ST_NOHIT;
    end

    // slot table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[id_reg] <= {px_reg, py_reg, q_reg[0][CW-1:0], div_quot[CW-1:0]};
        rd_reg <= mem[sc_reg[IW-1:0]];
    end

    assign {s_x, s_y, s_cx, s_cy} = rd_reg;
    assign dx  = (px_reg >= s_x) ? px_reg - s_x : s_x - px_reg;
    assign dy  = (py_reg >= s_y) ? py_reg - s_y : s_y - py_reg;
    assign dxe = shrq_pkg::RANGE_W'(dx);
    assign dye = shrq_pkg::RANGE_W'(dy);
    assign incell = (NW'(s_cx) >= q_reg[0]) && (NW'(s_cx) <= q_reg[1]) &&
                    (NW'(s_cy) >= q_reg[2]) && (NW'(s_cy) <= q_reg[3]);
    assign hit = (mode_reg == shrq_pkg::MODE_BOUND) ?
                 ((dxe == range_reg && dye <= range_reg) ||
                  (dye == range_reg && dxe <= range_reg)) :
                 (dxe <= range_reg && dye <= range_reg);

    always_ff @(posedge clk)
    begin
        p1_id_reg  <= sc_reg[IW-1:0];
        p1_sv_reg  <= slot_valid_reg[sc_reg[IW-1:0]];
        p2_id_reg  <= p1_id_reg;
        p2_x_reg   <= s_x;
        p2_y_reg   <= s_y;
        p2_dx_reg  <= dx;
        p2_dy_reg  <= dy;
        p3_id_reg  <= p2_id_reg;
        p3_x_reg   <= p2_x_reg;
        p3_y_reg   <= p2_y_reg;
        p3_dxx_reg <= p2_dx_reg * p2_dx_reg;
        p3_dyy_reg <= p2_dy_reg * p2_dy_reg;
        p4_id_reg  <= p3_id_reg;
        p4_x_reg   <= p3_x_reg;
        p4_y_reg   <= p3_y_reg;
        p4_d_reg   <= shrq_pkg::DIST_W'(p3_dxx_reg) + shrq_pkg::DIST_W'(p3_dyy_reg);
    end

    assign new_ent.valid = 1'b1;
    assign new_ent.dsq   = p4_d_reg;
    assign new_ent.id    = shrq_pkg::ID_W'(p4_id_reg);
    assign new_ent.x     = shrq_pkg::POS_W'(p4_x_reg);
    assign new_ent.y     = shrq_pkg::POS_W'(p4_y_reg);

    always_comb
    begin
        for (int i = 0; i < MAX_OBJECTS; i++)
        begin
            pent[i] = (i == 0) ? '0 : cent[(i == 0) ? 0 : i - 1];
            plt[i]  = (i == 0) ? 1'b0 : clt[(i == 0) ? 0 : i - 1];
            nent[i] = (i == MAX_OBJECTS - 1) ? '0 : cent[(i == MAX_OBJECTS - 1) ? i : i + 1];
        end
    end

    for (genvar g = 0; g < MAX_OBJECTS; g++)
    begin : g_chain
        shrq_sort_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .clear    (chain_clear),
            .ins      (p4_v_reg),
            .pop      (pop),
            .new_ent  (new_ent),
            .prev_ent (pent[g]),
            .prev_lt  (plt[g]),
            .next_ent (nent[g]),
            .ent      (cent[g]),
            .lt       (clt[g])
        );
    end

    assign emit_last = !cent[1].valid;

    assign rsp.valid       = (state_reg == S_EMIT) || (state_reg == S_RESP);
    assign rsp.status      = (state_reg == S_EMIT) ? shrq_pkg::ST_HIT : rstat_reg;
    assign rsp.hit_id      = (state_reg == S_EMIT) ? cent[0].id : '0;
    assign rsp.hit_x       = (state_reg == S_EMIT) ? cent[0].x : '0;
    assign rsp.hit_y       = (state_reg == S_EMIT) ? cent[0].y : '0;
    assign rsp.distance_sq = (state_reg == S_EMIT) ? cent[0].dsq : '0;
    assign rsp.last        = (state_reg == S_EMIT) ? emit_last : 1'b1;

    `SHRQ_ASSERT_NOW(a_no_overlap, req.ready, !rsp.valid, "input taken while result pending")
    `SHRQ_ASSERT_NOW(a_div_state, div_done, state_reg == S_DIV, "stray divider done")
    `SHRQ_ASSERT_NOW(a_chain_order, cent[1].valid, cent[0].dsq <= cent[1].dsq, "chain unordered")
    `SHRQ_ASSERT_NEXT(a_single_last, rsp_acc && rsp.last, req.ready, "busy after last beat")

endmodule

### test/tb.sv
// Self-checking testbench for spatial_hash_range_query: directed table, then random traffic.
// Depends on shrq_pkg, the channel interfaces in shrq_if and the top level; predicts every result beat.
`timescale 1ns / 100ps

module tb;

    localparam logic [shrq_pkg::KIND_W-1:0] KIND_IGNORED = 2'd3;
    localparam logic [1:0]                  MODE_SPARE   = 2'd3;
    localparam int                          SLOTS        = shrq_pkg::MAX_OBJECTS_DEF;
    localparam int                          SETTLE       = 150;
    localparam int                          CYCLE_LIMIT  = 2000000;
    localparam int                          RANDOM_ITEMS = 200;

    typedef enum logic { ROW_CFG, ROW_ITEM } row_op_t;

    typedef struct {
        row_op_t                         op;
        logic [shrq_pkg::CFG_AW-1:0]     addr;
        logic [shrq_pkg::CFG_DW-1:0]     data;
        logic [shrq_pkg::KIND_W-1:0]     kind;
        logic [shrq_pkg::ID_W-1:0]       id;
        logic [shrq_pkg::POS_W-1:0]      x;
        logic [shrq_pkg::POS_W-1:0]      y;
        logic                            typed;
        logic [shrq_pkg::STATUS_W-1:0]   status;
    } stim_row_t;

    typedef struct {
        logic [shrq_pkg::STATUS_W-1:0]   status;
        logic [shrq_pkg::ID_W-1:0]       hit_id;
        logic [shrq_pkg::POS_W-1:0]      hit_x;
        logic [shrq_pkg::POS_W-1:0]      hit_y;
        logic [shrq_pkg::DIST_W-1:0]     dsq;
        logic                            last;
    } hit_beat_t;

    logic clk = 1'b0;
    logic rst_n;
    int   cycles = 0;
    int   errors = 0;

    shrq_req_if req ();
    shrq_rsp_if rsp ();
    shrq_cfg_if cfg ();

    spatial_hash_range_query dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    // shadow of the block's registers and slot table
    logic [1:0]                       m_mode;
    logic [shrq_pkg::RANGE_W-1:0]     m_range;
    logic [shrq_pkg::GRID_W-1:0]      m_cell;
    logic [shrq_pkg::GRID_W-1:0]      m_gw;
    logic [shrq_pkg::GRID_W-1:0]      m_gh;
    logic                             s_valid [SLOTS];
    logic [shrq_pkg::POS_W-1:0]       s_x [SLOTS];
    logic [shrq_pkg::POS_W-1:0]       s_y [SLOTS];
    int                               s_cx [SLOTS];
    int                               s_cy [SLOTS];

    hit_beat_t pending_beats [$];
    stim_row_t rows [$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic void push_beat(logic [shrq_pkg::STATUS_W-1:0] st,
                                      logic [shrq_pkg::ID_W-1:0] id,
                                      logic [shrq_pkg::POS_W-1:0] x,
                                      logic [shrq_pkg::POS_W-1:0] y,
                                      logic [shrq_pkg::DIST_W-1:0] d, logic lst);
        hit_beat_t b;
        b.status = st; b.hit_id = id; b.hit_x = x; b.hit_y = y; b.dsq = d; b.last = lst;
        pending_beats.push_back(b);
    endfunction

    function automatic void apply_cfg(logic [shrq_pkg::CFG_AW-1:0] a,
                                      logic [shrq_pkg::CFG_DW-1:0] v);
        case (a)
            shrq_pkg::CFG_MODE:  m_mode  = v[1:0];
            shrq_pkg::CFG_RANGE: m_range = v[shrq_pkg::RANGE_W-1:0];
            shrq_pkg::CFG_CELL:  m_cell  = v[shrq_pkg::GRID_W-1:0];
            shrq_pkg::CFG_GW:    m_gw    = v[shrq_pkg::GRID_W-1:0];
            shrq_pkg::CFG_GH:    m_gh    = v[shrq_pkg::GRID_W-1:0];
            default:             ;
        endcase
    endfunction

    function automatic void predict_query(logic [shrq_pkg::KIND_W-1:0] kind,
                                          logic [shrq_pkg::ID_W-1:0] id,
                                          logic [shrq_pkg::POS_W-1:0] px,
                                          logic [shrq_pkg::POS_W-1:0] py);
        int cs, x, y, r, top, bottom, right, left, cxlo, cxhi, cylo, cyhi;
        int dx, dy, d, n, j;
        int hid [SLOTS];
        int hd [SLOTS];
        logic was, hit;
        cs = (m_cell == '0) ? 1 : int'(m_cell);
        if (kind == shrq_pkg::KIND_UPSERT)
        begin
            was = s_valid[id];
            s_valid[id] = 1'b1;
            s_x[id] = px; s_y[id] = py;
            s_cx[id] = int'(px) / cs; s_cy[id] = int'(py) / cs;
            push_beat(was ? shrq_pkg::ST_MOVED : shrq_pkg::ST_NEW, '0, '0, '0, '0, 1'b1);
            return;
        end
        if (kind == shrq_pkg::KIND_REMOVE)
        begin
            was = s_valid[id];
            s_valid[id] = 1'b0;
            push_beat(was ? shrq_pkg::ST_REMOVED : shrq_pkg::ST_NOTFOUND,
                      '0, '0, '0, '0, 1'b1);
            return;
        end
        if (kind != shrq_pkg::KIND_SEARCH)
            return;
        if (m_mode != shrq_pkg::MODE_BOUND && m_mode != shrq_pkg::MODE_AREA)
        begin
            push_beat(shrq_pkg::ST_MISCONF, '0, '0, '0, '0, 1'b1);
            return;
        end
        x = int'(px); y = int'(py); r = int'(m_range);
        top = (int'(m_gh) < y + r) ? int'(m_gh) : y + r;
        bottom = (y - r > 0) ? y - r : 0;
        right = (int'(m_gw) < x + r) ? int'(m_gw) : x + r;
        left = (x - r > 0) ? x - r : 0;
        cxlo = left / cs; cxhi = right / cs; cylo = bottom / cs; cyhi = top / cs;
        n = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!s_valid[i]) continue;
            if (s_cx[i] < cxlo || s_cx[i] > cxhi) continue;
            if (s_cy[i] < cylo || s_cy[i] > cyhi) continue;
            dx = x - int'(s_x[i]); if (dx < 0) dx = -dx;
            dy = y - int'(s_y[i]); if (dy < 0) dy = -dy;
            if (m_mode == shrq_pkg::MODE_BOUND)
                hit = (dx == r && dy <= r) || (dy == r && dx <= r);
            else
                hit = dx <= r && dy <= r;
            if (!hit) continue;
            d = dx * dx + dy * dy;
            j = n;
            while (j > 0 && hd[j-1] > d)
            begin
                hd[j] = hd[j-1]; hid[j] = hid[j-1]; j--;
            end
            hd[j] = d; hid[j] = i;
            n++;
        end
        if (n == 0)
        begin
            push_beat(shrq_pkg::ST_NOHIT, '0, '0, '0, '0, 1'b1);
            return;
        end
        for (int i = 0; i < n; i++)
            push_beat(shrq_pkg::ST_HIT, shrq_pkg::ID_W'(hid[i]), s_x[hid[i]], s_y[hid[i]],
                      shrq_pkg::DIST_W'(hd[i]), i == n - 1);
    endfunction

    // called at a clock edge; returns at the edge where the beat is taken, valid still high
    task automatic send_query(logic [shrq_pkg::KIND_W-1:0] kind,
                              logic [shrq_pkg::ID_W-1:0] id,
                              logic [shrq_pkg::POS_W-1:0] x,
                              logic [shrq_pkg::POS_W-1:0] y);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid     <= 1'b1;
        req.kind      <= kind;
        req.object_id <= id;
        req.pos_x     <= x;
        req.pos_y     <= y;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        predict_query(kind, id, x, y);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending_beats.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [shrq_pkg::CFG_AW-1:0] a, logic [shrq_pkg::CFG_DW-1:0] v);
        cfg.valid <= 1'b1;
        cfg.addr  <= a;
        cfg.data  <= v;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        cfg.valid <= 1'b0;
        apply_cfg(a, v);
        @(posedge clk);
    endtask

    task automatic run_row(stim_row_t row);
        if (row.op == ROW_CFG)
        begin
            drain();
            write_reg(row.addr, row.data);
        end
        else
        begin
            send_query(row.kind, row.id, row.x, row.y);
            if (row.typed && pending_beats.size() != 0)
                pending_beats[$].status = row.status;
        end
    endtask

    function automatic void add_cfg(logic [shrq_pkg::CFG_AW-1:0] a,
                                    logic [shrq_pkg::CFG_DW-1:0] v);
        stim_row_t r;
        r.op = ROW_CFG; r.addr = a; r.data = v;
        r.kind = '0; r.id = '0; r.x = '0; r.y = '0; r.typed = 1'b0; r.status = '0;
        rows.push_back(r);
    endfunction

    function automatic void add_item(logic [shrq_pkg::KIND_W-1:0] k,
                                     logic [shrq_pkg::ID_W-1:0] id,
                                     logic [shrq_pkg::POS_W-1:0] x,
                                     logic [shrq_pkg::POS_W-1:0] y,
                                     logic typed, logic [shrq_pkg::STATUS_W-1:0] st);
        stim_row_t r;
        r.op = ROW_ITEM; r.addr = '0; r.data = '0;
        r.kind = k; r.id = id; r.x = x; r.y = y; r.typed = typed; r.status = st;
        rows.push_back(r);
    endfunction

    // result side: random back-pressure, compare against the oldest expectation
    initial
    begin
        hit_beat_t e;
        int stall;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            @(posedge clk);
            while (!rsp.valid) @(posedge clk);
            if (pending_beats.size() == 0)
            begin
                $display("%0t unexpected beat status=%0d id=%0d", $time, rsp.status, rsp.hit_id);
                errors++;
            end
            else
            begin
                e = pending_beats.pop_front();
                if (rsp.status !== e.status)
                begin
                    $display("%0t status exp=%0d act=%0d", $time, e.status, rsp.status);
                    errors++;
                end
                if (rsp.hit_id !== e.hit_id)
                begin
                    $display("%0t hit_id exp=%0d act=%0d", $time, e.hit_id, rsp.hit_id);
                    errors++;
                end
                if (rsp.hit_x !== e.hit_x)
                begin
                    $display("%0t hit_x exp=%0d act=%0d", $time, e.hit_x, rsp.hit_x);
                    errors++;
                end
                if (rsp.hit_y !== e.hit_y)
                begin
                    $display("%0t hit_y exp=%0d act=%0d", $time, e.hit_y, rsp.hit_y);
                    errors++;
                end
                if (rsp.distance_sq !== e.dsq)
                begin
                    $display("%0t distance_sq exp=%0d act=%0d", $time, e.dsq, rsp.distance_sq);
                    errors++;
                end
                if (rsp.last !== e.last)
                begin
                    $display("%0t last exp=%0d act=%0d", $time, e.last, rsp.last);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int cx, cy, k;
        rst_n         = 1'b0;
        req.valid     = 1'b0;
        req.kind      = '0;
        req.object_id = '0;
        req.pos_x     = '0;
        req.pos_y     = '0;
        cfg.valid     = 1'b0;
        cfg.addr      = '0;
        cfg.data      = '0;
        m_mode = shrq_pkg::MODE_NONE; m_range = 10'd1; m_cell = 11'd8;
        m_gw = 11'd1024; m_gh = 11'd1024;
        for (int i = 0; i < SLOTS; i++)
        begin
            s_valid[i] = 1'b0; s_x[i] = '0; s_y[i] = '0; s_cx[i] = 0; s_cy[i] = 0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset state: no mode, empty table
        add_item(shrq_pkg::KIND_SEARCH, 6'd0, 10'd10, 10'd10, 1'b1, shrq_pkg::ST_MISCONF);
        add_item(shrq_pkg::KIND_REMOVE, 6'd5, 10'd0, 10'd0, 1'b1, shrq_pkg::ST_NOTFOUND);
        add_item(shrq_pkg::KIND_UPSERT, 6'd0, 10'd0, 10'd0, 1'b1, shrq_pkg::ST_NEW);
        add_item(shrq_pkg::KIND_UPSERT, 6'd63, 10'd1023, 10'd1023, 1'b1, shrq_pkg::ST_NEW);
        add_item(shrq_pkg::KIND_UPSERT, 6'd0, 10'd2, 10'd1, 1'b1, shrq_pkg::ST_MOVED);
        add_item(shrq_pkg::KIND_UPSERT, 6'd1, 10'd3, 10'd3, 1'b1, shrq_pkg::ST_NEW);
        add_item(KIND_IGNORED, 6'd7, 10'd5, 10'd5, 1'b0, shrq_pkg::ST_NEW);
        add_cfg(shrq_pkg::CFG_MODE, shrq_pkg::CFG_DW'(MODE_SPARE));
        add_item(shrq_pkg::KIND_SEARCH, 6'd0, 10'd2, 10'd2, 1'b1, shrq_pkg::ST_MISCONF);
        add_cfg(shrq_pkg::CFG_MODE, shrq_pkg::CFG_DW'(shrq_pkg::MODE_AREA));
        add_item(shrq_pkg::KIND_SEARCH, 6'd0, 10'd2, 10'd2, 1'b0, shrq_pkg::ST_NEW);
        add_item(shrq_pkg::KIND_SEARCH, 6'd0, 10'd500, 10'd500, 1'b1, shrq_pkg::ST_NOHIT);
        add_item(shrq_pkg::KIND_SEARCH, 6'd0, 10'd1023, 10'd1023, 1'b0, shrq_pkg::ST_NEW);
        add_cfg(shrq_pkg::CFG_MODE, shrq_pkg::CFG_DW'(shrq_pkg::MODE_BOUND));
        add_cfg(shrq_pkg::CFG_RANGE, 11'd1023);
        add_item(shrq_pkg::KIND_SEARCH, 6'd0, 10'd0, 10'd0, 1'b0, shrq_pkg::ST_NEW);
        add_cfg(shrq_pkg::CFG_CELL, 11'd0);
        add_cfg(shrq_pkg::CFG_GW, 11'd1);
        add_cfg(shrq_pkg::CFG_GH, 11'd2047);
        add_item(shrq_pkg::KIND_UPSERT, 6'd2, 10'd1, 10'd1, 1'b1, shrq_pkg::ST_NEW);
        add_item(shrq_pkg::KIND_SEARCH, 6'd0, 10'd1023, 10'd0, 1'b0, shrq_pkg::ST_NEW);
        add_cfg(shrq_pkg::CFG_RANGE, 11'd0);
        add_item(shrq_pkg::KIND_SEARCH, 6'd0, 10'd1, 10'd1, 1'b0, shrq_pkg::ST_NEW);
        add_item(shrq_pkg::KIND_REMOVE, 6'd63, 10'd0, 10'd0, 1'b1, shrq_pkg::ST_REMOVED);
        add_item(shrq_pkg::KIND_REMOVE, 6'd63, 10'd0, 10'd0, 1'b1, shrq_pkg::ST_NOTFOUND);
        foreach (rows[i])
            run_row(rows[i]);

        cx = 0; cy = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 40 == 0)
            begin
                drain();
                write_reg(shrq_pkg::CFG_MODE,
                          shrq_pkg::CFG_DW'(($urandom_range(0, 7) == 0) ?
                                            $urandom_range(0, 3) : $urandom_range(1, 2)));
                write_reg(shrq_pkg::CFG_RANGE,
                          shrq_pkg::CFG_DW'(($urandom_range(0, 5) == 0) ?
                                            $urandom_range(0, 1023) : $urandom_range(0, 40)));
                write_reg(shrq_pkg::CFG_CELL,
                          shrq_pkg::CFG_DW'(($urandom_range(0, 3) == 0) ?
                                            $urandom_range(0, 2047) : $urandom_range(1, 64)));
                write_reg(shrq_pkg::CFG_GW,
                          shrq_pkg::CFG_DW'(($urandom_range(0, 3) == 0) ?
                                            $urandom_range(0, 2047) : 1024));
                write_reg(shrq_pkg::CFG_GH,
                          shrq_pkg::CFG_DW'(($urandom_range(0, 3) == 0) ?
                                            $urandom_range(0, 2047) : 1024));
                cx = $urandom_range(0, 1023);
                cy = $urandom_range(0, 1023);
            end
            k = $urandom_range(0, 9);
            if (k < 4)
                send_query(shrq_pkg::KIND_UPSERT, shrq_pkg::ID_W'($urandom_range(0, 63)),
                           shrq_pkg::POS_W'((cx + $urandom_range(0, 60)) % 1024),
                           shrq_pkg::POS_W'((cy + $urandom_range(0, 60)) % 1024));
            else if (k < 5)
                send_query(shrq_pkg::KIND_REMOVE, shrq_pkg::ID_W'($urandom_range(0, 63)),
                           shrq_pkg::POS_W'($urandom), shrq_pkg::POS_W'($urandom));
            else if (k < 9)
                send_query(shrq_pkg::KIND_SEARCH, shrq_pkg::ID_W'($urandom),
                           shrq_pkg::POS_W'((cx + $urandom_range(0, 60)) % 1024),
                           shrq_pkg::POS_W'((cy + $urandom_range(0, 60)) % 1024));
            else
                send_query(shrq_pkg::KIND_W'($urandom_range(0, 3)), shrq_pkg::ID_W'($urandom),
                           shrq_pkg::POS_W'($urandom), shrq_pkg::POS_W'($urandom));
        end
        drain();

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
